// ===== design/msv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msv_pkg
// Shared types and fixed port widths of the mesh signed volume block.
// ----------------------------------------------------------------------------
package msv_pkg;

  localparam int COORD_PORT_W = 16;
  localparam int VOL_W        = 64;

  typedef struct packed {
    logic add;
    logic last;
  } vol_ctl_t;

  localparam int CTL_W = $bits(vol_ctl_t);

endpackage

// ===== design/msv_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msv_queue
// Small register queue between the vertex front end and the volume back end.
// ----------------------------------------------------------------------------
module msv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             wr_ok, rd_ok;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr_ok = wr_en && !full;
  assign rd_ok = rd_en && !empty;
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (wr_ok) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
    end
    if (rd_ok) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
    end
    cnt_nxt = cnt_r + {{AW{1'b0}}, wr_ok} - {{AW{1'b0}}, rd_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== design/msv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msv_front
// Vertex front end: tracks face first and previous vertex, builds fan jobs.
// ----------------------------------------------------------------------------
module msv_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    accept,
  input  logic signed [msv_pkg::COORD_PORT_W-1:0] x_coord,
  input  logic signed [msv_pkg::COORD_PORT_W-1:0] y_coord,
  input  logic signed [msv_pkg::COORD_PORT_W-1:0] z_coord,
  input  logic                                    face_start,
  input  logic                                    mesh_last,
  output logic [3*COORD_BITS-1:0]                 job_a,
  output logic [3*COORD_BITS-1:0]                 job_b,
  output logic [3*COORD_BITS-1:0]                 job_c,
  output msv_pkg::vol_ctl_t                       job_ctl
);

  import msv_pkg::*;

  localparam int EXT_W = (COORD_BITS > COORD_PORT_W) ? COORD_BITS : COORD_PORT_W;

  logic [EXT_W-1:0]        x_ext, y_ext, z_ext;
  logic [3*COORD_BITS-1:0] cur;
  logic [3*COORD_BITS-1:0] first_r, first_nxt;
  logic [3*COORD_BITS-1:0] prev_r, prev_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    opens;

  assign x_ext = EXT_W'($unsigned(x_coord));
  assign y_ext = EXT_W'($unsigned(y_coord));
  assign z_ext = EXT_W'($unsigned(z_coord));
  assign cur   = {x_ext[COORD_BITS-1:0], y_ext[COORD_BITS-1:0], z_ext[COORD_BITS-1:0]};

  assign opens        = face_start || (cnt_r == 2'd0);
  assign job_a        = first_r;
  assign job_b        = prev_r;
  assign job_c        = cur;
  assign job_ctl.add  = !opens && (cnt_r == 2'd2);
  assign job_ctl.last = mesh_last;

  always_comb begin
    first_nxt = first_r;
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (opens) begin
        first_nxt = cur;
        cnt_nxt   = 2'd1;
      end else if (cnt_r == 2'd1) begin
        cnt_nxt = 2'd2;
      end
      prev_nxt = cur;
      if (mesh_last) begin
        cnt_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    prev_r  <= prev_nxt;
  end

endmodule

// ===== design/msv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msv_back
// Volume back end: pipelined triple product, saturating accumulate, result
// register.
// ----------------------------------------------------------------------------
module msv_back #(
  parameter int COORD_BITS = 16,
  parameter int ACC_BITS   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             job_valid,
  input  logic [3*COORD_BITS-1:0]          job_a,
  input  logic [3*COORD_BITS-1:0]          job_b,
  input  logic [3*COORD_BITS-1:0]          job_c,
  input  msv_pkg::vol_ctl_t                job_ctl,
  output logic                             job_take,
  input  logic                             pop,
  output logic                             empty,
  output logic signed [msv_pkg::VOL_W-1:0] six_volume,
  output logic                             overflow
);

  import msv_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int PW     = 2*C;
  localparam int XW     = 2*C + 1;
  localparam int TW     = 3*C + 1;
  localparam int TERM_W = 3*C + 3;
  localparam int SUM_W  = ((TERM_W > ACC_BITS) ? TERM_W : ACC_BITS) + 1;

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    SUM_W'(signed'({1'b0, {(ACC_BITS-1){1'b1}}}));
  localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

  logic signed [C-1:0] bx, by, bz, cx, cy, cz, ax, ay, az;

  logic                 go;
  logic                 s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt, s3_v_r, s3_v_nxt;
  vol_ctl_t             s1_ctl_r, s1_ctl_nxt, s2_ctl_r, s2_ctl_nxt, s3_ctl_r, s3_ctl_nxt;
  logic [3*C-1:0]       s1_a_r, s1_a_nxt, s2_a_r, s2_a_nxt;
  logic signed [PW-1:0] s1_p_r [6];
  logic signed [PW-1:0] s1_p_nxt [6];
  logic signed [XW-1:0] s2_x_r [3];
  logic signed [XW-1:0] s2_x_nxt [3];
  logic signed [TW-1:0] s3_t_r [3];
  logic signed [TW-1:0] s3_t_nxt [3];

  logic signed [TERM_W-1:0]   term;
  logic signed [SUM_W-1:0]    sum;
  logic signed [ACC_BITS-1:0] acc_sat, acc_fin;
  logic                       sat_hit, ovf_fin;
  logic signed [ACC_BITS-1:0] acc_r, acc_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       out_v_r, out_v_nxt;
  logic signed [VOL_W-1:0]    out_vol_r, out_vol_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  assign bx = job_b[3*C-1:2*C];
  assign by = job_b[2*C-1:C];
  assign bz = job_b[C-1:0];
  assign cx = job_c[3*C-1:2*C];
  assign cy = job_c[2*C-1:C];
  assign cz = job_c[C-1:0];
  assign ax = s2_a_r[3*C-1:2*C];
  assign ay = s2_a_r[2*C-1:C];
  assign az = s2_a_r[C-1:0];

  // stall only when a mesh result would land on an occupied result register
  assign go       = !(s3_v_r && s3_ctl_r.last && out_v_r && !pop);
  assign job_take = go && job_valid;

  always_comb begin
    s1_v_nxt    = s1_v_r;
    s1_ctl_nxt  = s1_ctl_r;
    s1_a_nxt    = s1_a_r;
    s1_p_nxt    = s1_p_r;
    s2_v_nxt    = s2_v_r;
    s2_ctl_nxt  = s2_ctl_r;
    s2_a_nxt    = s2_a_r;
    s2_x_nxt    = s2_x_r;
    s3_v_nxt    = s3_v_r;
    s3_ctl_nxt  = s3_ctl_r;
    s3_t_nxt    = s3_t_r;
    if (go) begin
      s1_v_nxt    = job_valid;
      s1_ctl_nxt  = job_ctl;
      s1_a_nxt    = job_a;
      s1_p_nxt[0] = PW'(by) * PW'(cz);
      s1_p_nxt[1] = PW'(bz) * PW'(cy);
      s1_p_nxt[2] = PW'(bx) * PW'(cz);
      s1_p_nxt[3] = PW'(bz) * PW'(cx);
      s1_p_nxt[4] = PW'(bx) * PW'(cy);
      s1_p_nxt[5] = PW'(by) * PW'(cx);
      s2_v_nxt    = s1_v_r;
      s2_ctl_nxt  = s1_ctl_r;
      s2_a_nxt    = s1_a_r;
      s2_x_nxt[0] = XW'(s1_p_r[0]) - XW'(s1_p_r[1]);
      s2_x_nxt[1] = XW'(s1_p_r[2]) - XW'(s1_p_r[3]);
      s2_x_nxt[2] = XW'(s1_p_r[4]) - XW'(s1_p_r[5]);
      s3_v_nxt    = s2_v_r;
      s3_ctl_nxt  = s2_ctl_r;
      s3_t_nxt[0] = TW'(ax) * TW'(s2_x_r[0]);
      s3_t_nxt[1] = TW'(ay) * TW'(s2_x_r[1]);
      s3_t_nxt[2] = TW'(az) * TW'(s2_x_r[2]);
    end
  end

  always_comb begin
    term = TERM_W'(s3_t_r[0]) - TERM_W'(s3_t_r[1]) + TERM_W'(s3_t_r[2]);
    sum  = SUM_W'(acc_r) + SUM_W'(term);
    if (sum > ACC_MAX) begin
      acc_sat = ACC_MAX[ACC_BITS-1:0];
      sat_hit = 1'b1;
    end else if (sum < ACC_MIN) begin
      acc_sat = ACC_MIN[ACC_BITS-1:0];
      sat_hit = 1'b1;
    end else begin
      acc_sat = sum[ACC_BITS-1:0];
      sat_hit = 1'b0;
    end
    acc_fin = s3_ctl_r.add ? acc_sat : acc_r;
    ovf_fin = ovf_r || (s3_ctl_r.add && sat_hit);
  end

  always_comb begin
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    out_v_nxt   = out_v_r && !pop;
    out_vol_nxt = out_vol_r;
    out_ovf_nxt = out_ovf_r;
    if (go && s3_v_r) begin
      acc_nxt = acc_fin;
      ovf_nxt = ovf_fin;
      if (s3_ctl_r.last) begin
        out_v_nxt   = 1'b1;
        out_vol_nxt = VOL_W'(acc_fin);
        out_ovf_nxt = ovf_fin;
        acc_nxt     = '0;
        ovf_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r  <= s1_ctl_nxt;
    s1_a_r    <= s1_a_nxt;
    s1_p_r    <= s1_p_nxt;
    s2_ctl_r  <= s2_ctl_nxt;
    s2_a_r    <= s2_a_nxt;
    s2_x_r    <= s2_x_nxt;
    s3_ctl_r  <= s3_ctl_nxt;
    s3_t_r    <= s3_t_nxt;
    out_vol_r <= out_vol_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign empty      = !out_v_r;
  assign six_volume = out_vol_r;
  assign overflow   = out_ovf_r;

endmodule

// ===== design/mesh_signed_volume.sv =====
`timescale 1ns / 1ps
// Path: a mesh-last word passes the queue, product stages s1, s2, s3 and the result register.
// Throughput: one vertex word per cycle unless the back end stalls on an unpopped
// result, set by the 3-stage product pipeline and the saturating accumulate.
// Reset: synchronous active-low rst_n empties the queue, the pipeline and the
// result register and clears the accumulator and overflow flag.
// ----------------------------------------------------------------------------
// mesh_signed_volume
// Six times the signed volume of a streamed polygon mesh, saturating.
// ----------------------------------------------------------------------------
module mesh_signed_volume #(
  parameter int COORD_BITS = 16,
  parameter int ACC_BITS   = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [msv_pkg::COORD_PORT_W-1:0] in_x_coord,
  input  logic signed [msv_pkg::COORD_PORT_W-1:0] in_y_coord,
  input  logic signed [msv_pkg::COORD_PORT_W-1:0] in_z_coord,
  input  logic                                    in_face_start,
  input  logic                                    in_mesh_last,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [msv_pkg::VOL_W-1:0]        out_six_volume,
  output logic                                    out_overflow
);

  import msv_pkg::*;

  localparam int VW = 3*COORD_BITS;
  localparam int QW = 3*VW + CTL_W;

  logic            accept;
  logic [VW-1:0]   f_a, f_b, f_c;
  vol_ctl_t        f_ctl;
  logic [QW-1:0]   q_rdata;
  logic            q_empty, q_take;
  logic [VW-1:0]   b_a, b_b, b_c;
  vol_ctl_t        b_ctl;

  assign accept = push && !full;

  msv_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .x_coord   (in_x_coord),
    .y_coord   (in_y_coord),
    .z_coord   (in_z_coord),
    .face_start(in_face_start),
    .mesh_last (in_mesh_last),
    .job_a     (f_a),
    .job_b     (f_b),
    .job_c     (f_c),
    .job_ctl   (f_ctl)
  );

  msv_queue #(
    .WIDTH(QW),
    .DEPTH(4)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .wr_en(accept),
    .wdata({f_a, f_b, f_c, f_ctl}),
    .rd_en(q_take),
    .rdata(q_rdata),
    .full (full),
    .empty(q_empty)
  );

  assign {b_a, b_b, b_c, b_ctl} = q_rdata;

  msv_back #(
    .COORD_BITS(COORD_BITS),
    .ACC_BITS  (ACC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job_a     (b_a),
    .job_b     (b_b),
    .job_c     (b_c),
    .job_ctl   (b_ctl),
    .job_take  (q_take),
    .pop       (pop),
    .empty     (empty),
    .six_volume(out_six_volume),
    .overflow  (out_overflow)
  );

endmodule

// ===== design/msv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msv_checker
// Port-level checks of the mesh signed volume block, bound to the top level.
// ----------------------------------------------------------------------------
module msv_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    push,
  input logic                                    full,
  input logic signed [msv_pkg::COORD_PORT_W-1:0] in_x_coord,
  input logic signed [msv_pkg::COORD_PORT_W-1:0] in_y_coord,
  input logic signed [msv_pkg::COORD_PORT_W-1:0] in_z_coord,
  input logic                                    in_face_start,
  input logic                                    in_mesh_last,
  input logic                                    empty,
  input logic                                    pop,
  input logic signed [msv_pkg::VOL_W-1:0]        out_six_volume,
  input logic                                    out_overflow
);

  import msv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_six_volume) && $stable(out_overflow)))
    else $error("result word changed while waiting");

  a_reset_latency: assert property (@(posedge clk)
    !rst_n |=> (empty && !full) ##1 empty ##1 empty ##1 empty)
    else $error("result appeared faster than pipeline depth after reset");

  a_empty_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(empty) |-> $past(pop))
    else $error("result word dropped without pop");

endmodule

bind mesh_signed_volume msv_checker u_msv_checker (.*);

// ===== bench/msv_volume_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msv_volume_checker
// Watches the vertex and volume queues of mesh_signed_volume, folds every
// accepted vertex into its own fan-triangulation volume sum and compares
// each popped volume word field by field with the oldest one predicted.
// ----------------------------------------------------------------------------
module msv_volume_checker #(
  parameter int COORD_BITS = 16,
  parameter int ACC_BITS   = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    push,
  input  logic                                    full,
  input  logic signed [msv_pkg::COORD_PORT_W-1:0] in_x_coord,
  input  logic signed [msv_pkg::COORD_PORT_W-1:0] in_y_coord,
  input  logic signed [msv_pkg::COORD_PORT_W-1:0] in_z_coord,
  input  logic                                    in_face_start,
  input  logic                                    in_mesh_last,
  input  logic                                    empty,
  input  logic                                    pop,
  input  logic signed [msv_pkg::VOL_W-1:0]        out_six_volume,
  input  logic                                    out_overflow,
  output int                                      fails,
  output int                                      pending
);

  localparam logic signed [64:0] ACC_MAX = (65'sd1 <<< (ACC_BITS - 1)) - 65'sd1;
  localparam logic signed [64:0] ACC_MIN = -ACC_MAX - 65'sd1;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } grid_pt_t;

  typedef struct {
    logic signed [msv_pkg::VOL_W-1:0] six_volume;
    logic                             overflow;
  } vol_word_t;

  grid_pt_t          fan_apex;
  grid_pt_t          prev_pt;
  logic [1:0]        face_len;
  logic signed [64:0] vol_sum;
  logic              sum_clamped;
  vol_word_t         volume_due[$];
  int                miss_count = 0;

  assign fails   = miss_count;
  assign pending = volume_due.size();

  task automatic note_mismatch(input string what);
    miss_count++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  function automatic logic signed [COORD_BITS-1:0] to_grid(
    input logic [msv_pkg::COORD_PORT_W-1:0] raw
  );
    return raw[COORD_BITS-1:0];
  endfunction

  function automatic longint triple_product(input grid_pt_t a, b, c);
    longint cx, cy, cz;
    cx = longint'(b.y) * longint'(c.z) - longint'(b.z) * longint'(c.y);
    cy = longint'(b.x) * longint'(c.z) - longint'(b.z) * longint'(c.x);
    cz = longint'(b.x) * longint'(c.y) - longint'(b.y) * longint'(c.x);
    return longint'(a.x) * cx - longint'(a.y) * cy + longint'(a.z) * cz;
  endfunction

  task automatic clear_volume();
    fan_apex    = '{default: '0};
    prev_pt     = '{default: '0};
    face_len    = 2'd0;
    vol_sum     = '0;
    sum_clamped = 1'b0;
  endtask

  // fan triangulation from the face's first vertex, saturating sum
  task automatic fold_vertex();
    grid_pt_t           cur;
    logic signed [64:0] s;
    vol_word_t          done_word;
    cur.x = to_grid(in_x_coord);
    cur.y = to_grid(in_y_coord);
    cur.z = to_grid(in_z_coord);
    if (in_face_start || face_len == 2'd0) begin
      fan_apex = cur;
      face_len = 2'd1;
    end else if (face_len >= 2'd2) begin
      s = vol_sum + triple_product(fan_apex, prev_pt, cur);
      if (s > ACC_MAX) begin
        vol_sum     = ACC_MAX;
        sum_clamped = 1'b1;
      end else if (s < ACC_MIN) begin
        vol_sum     = ACC_MIN;
        sum_clamped = 1'b1;
      end else begin
        vol_sum = s;
      end
    end else begin
      face_len = 2'd2;
    end
    prev_pt = cur;
    if (in_mesh_last) begin
      done_word.six_volume = vol_sum[63:0];
      done_word.overflow   = sum_clamped;
      volume_due.insert(volume_due.size(), done_word);
      clear_volume();
    end
  endtask

  always @(posedge clk) begin
    vol_word_t want;
    if (!rst_n) begin
      clear_volume();
      volume_due.delete();
    end else begin
      if (pop && !empty) begin
        if (volume_due.size() == 0) begin
          note_mismatch($sformatf("unexpected word six_volume %0d overflow %0b",
                                  out_six_volume, out_overflow));
        end else begin
          want = volume_due.pop_front();
          if (out_six_volume !== want.six_volume)
            note_mismatch($sformatf("six_volume got %0d want %0d",
                                    out_six_volume, want.six_volume));
          if (out_overflow !== want.overflow)
            note_mismatch($sformatf("overflow got %0b want %0b",
                                    out_overflow, want.overflow));
        end
      end
      if (push && !full) fold_vertex();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for mesh_signed_volume: directed meshes (open faces, extremes,
// degenerate faces, long fans of extreme terms of both signs), then random
// meshes with random gaps on both queues; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int COORD_BITS     = 16;
  localparam int ACC_BITS       = 64;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int RANDOM_WORDS   = 1500;
  localparam int FAN_TERMS      = 40;
  localparam logic signed [15:0] CMAX = 16'sh7fff;
  localparam logic signed [15:0] CMIN = -16'sh8000;

  logic                                    clk = 1'b0;
  logic                                    rst_n;
  logic                                    push;
  logic                                    full;
  logic signed [msv_pkg::COORD_PORT_W-1:0] in_x_coord;
  logic signed [msv_pkg::COORD_PORT_W-1:0] in_y_coord;
  logic signed [msv_pkg::COORD_PORT_W-1:0] in_z_coord;
  logic                                    in_face_start;
  logic                                    in_mesh_last;
  logic                                    empty;
  logic                                    pop;
  logic signed [msv_pkg::VOL_W-1:0]        out_six_volume;
  logic                                    out_overflow;

  int fails;
  int pending;
  int stall_run;
  bit calm;
  int fed;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mesh_signed_volume #(
    .COORD_BITS(COORD_BITS),
    .ACC_BITS  (ACC_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_z_coord    (in_z_coord),
    .in_face_start (in_face_start),
    .in_mesh_last  (in_mesh_last),
    .empty         (empty),
    .pop           (pop),
    .out_six_volume(out_six_volume),
    .out_overflow  (out_overflow)
  );

  msv_volume_checker #(
    .COORD_BITS(COORD_BITS),
    .ACC_BITS  (ACC_BITS)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_z_coord    (in_z_coord),
    .in_face_start (in_face_start),
    .in_mesh_last  (in_mesh_last),
    .empty         (empty),
    .pop           (pop),
    .out_six_volume(out_six_volume),
    .out_overflow  (out_overflow),
    .fails         (fails),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_run <= 0;
    end else begin
      stall_run <= stall_run + 1;
      if (stall_run + 1 >= WATCHDOG_LIMIT) begin
        $display("mesh_signed_volume regression: fail");
        $finish;
      end
    end
  end

  task automatic feed_vertex(input logic signed [15:0] x, y, z, input bit fs, ml);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push          <= 1'b1;
    in_x_coord    <= x;
    in_y_coord    <= y;
    in_z_coord    <= z;
    in_face_start <= fs;
    in_mesh_last  <= ml;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return CMIN;
      1:       return CMAX;
      2, 3, 4: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // apex (K,K,K) with three points cycled about it: every term is +/-4K^3
  task automatic long_fan_mesh(input bit upward);
    logic signed [15:0] cx[3];
    logic signed [15:0] cy[3];
    logic signed [15:0] cz[3];
    int j;
    int step;
    cx[0] = CMAX;  cy[0] = -CMAX; cz[0] = -CMAX;
    cx[1] = -CMAX; cy[1] = CMAX;  cz[1] = -CMAX;
    cx[2] = -CMAX; cy[2] = -CMAX; cz[2] = CMAX;
    step = upward ? 1 : 2;
    j = 0;
    feed_vertex(CMAX, CMAX, CMAX, 1'b1, 1'b0);
    feed_vertex(cx[j], cy[j], cz[j], 1'b0, 1'b0);
    repeat (FAN_TERMS) begin
      j = (j + step) % 3;
      feed_vertex(cx[j], cy[j], cz[j], 1'b0, 1'b0);
    end
    // turn back the other way for a few terms
    for (int k = 0; k < 4; k++) begin
      j = (j + 3 - step) % 3;
      feed_vertex(cx[j], cy[j], cz[j], 1'b0, k == 3);
    end
  endtask

  task automatic random_mesh();
    int faces;
    int verts;
    bit fs;
    bit ml;
    faces = $urandom_range(1, 5);
    for (int f = 0; f < faces; f++) begin
      verts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      for (int v = 0; v < verts; v++) begin
        fs = (v == 0);
        ml = (f == faces - 1) && (v == verts - 1);
        if ($urandom_range(0, 11) == 0) begin
          fs = $urandom_range(0, 1);
          ml = ($urandom_range(0, 15) == 0);
        end
        feed_vertex(pick_coord(), pick_coord(), pick_coord(), fs, ml);
        fed++;
      end
    end
  endtask

  initial begin
    int gap;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin
    rst_n         = 1'b0;
    push          = 1'b0;
    in_x_coord    = '0;
    in_y_coord    = '0;
    in_z_coord    = '0;
    in_face_start = 1'b0;
    in_mesh_last  = 1'b0;
    calm          = 1'b0;
    fed           = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no open face after reset, then an extreme triangle
    feed_vertex(CMAX, CMIN, 16'sd0, 1'b0, 1'b0);
    feed_vertex(16'sd0, CMAX, CMIN, 1'b0, 1'b0);
    feed_vertex(CMIN, 16'sd0, CMAX, 1'b0, 1'b0);
    feed_vertex(CMIN, CMIN, CMIN, 1'b1, 1'b0);
    feed_vertex(CMAX, CMIN, CMAX, 1'b0, 1'b0);
    feed_vertex(CMIN, CMAX, CMAX, 1'b0, 1'b1);
    // single-vertex mesh
    feed_vertex(CMAX, CMAX, CMAX, 1'b1, 1'b1);
    // one- and two-vertex faces, a quad, a pentagon
    feed_vertex(16'sd5, 16'sd7, -16'sd3, 1'b1, 1'b0);
    feed_vertex(16'sd9, -16'sd2, 16'sd4, 1'b1, 1'b0);
    feed_vertex(-16'sd8, 16'sd1, 16'sd6, 1'b0, 1'b0);
    feed_vertex(16'sd100, 16'sd0, 16'sd0, 1'b1, 1'b0);
    feed_vertex(16'sd0, 16'sd100, 16'sd0, 1'b0, 1'b0);
    feed_vertex(16'sd0, 16'sd0, 16'sd100, 1'b0, 1'b0);
    feed_vertex(-16'sd50, -16'sd50, 16'sd70, 1'b0, 1'b0);
    feed_vertex(CMAX, 16'sd1, -16'sd1, 1'b1, 1'b0);
    feed_vertex(16'sd2, CMIN, 16'sd3, 1'b0, 1'b0);
    feed_vertex(-16'sd4, 16'sd5, CMAX, 1'b0, 1'b0);
    feed_vertex(CMIN, -16'sd6, 16'sd7, 1'b0, 1'b0);
    feed_vertex(16'sd8, CMAX, CMIN, 1'b0, 1'b1);
    // mesh end with no open face
    feed_vertex(CMIN, CMIN, CMIN, 1'b0, 1'b1);

    calm = 1'b1;
    long_fan_mesh(1'b1);
    long_fan_mesh(1'b0);

    while (fed < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      random_mesh();
    end
    calm = 1'b0;

    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (fails == 0) begin
      $display("mesh_signed_volume regression: pass");
    end else begin
      $display("mesh_signed_volume regression: fail");
    end
    $finish;
  end

endmodule
